@@ hdl/hds_pkg.sv @@
// Shared types and constants for the hangar door sequencer.
package hds_pkg;

  typedef enum logic [2:0] {
    MODE_REST     = 3'd0,
    MODE_TAKE_OFF = 3'd1,
    MODE_OUT      = 3'd2,
    MODE_LANDING  = 3'd3,
    MODE_ALARM    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    MSG_NONE     = 3'd0,
    MSG_INSIDE   = 3'd1,
    MSG_TAKE_OFF = 3'd2,
    MSG_OUT      = 3'd3,
    MSG_LANDING  = 3'd4,
    MSG_ALARM    = 3'd5,
    MSG_REST     = 3'd6
  } msg_t;

  localparam logic       FUNC_TICK  = 1'b0;
  localparam logic       FUNC_ALARM = 1'b1;

  localparam logic [1:0] CMD_NONE     = 2'd0;
  localparam logic [1:0] CMD_TAKE_OFF = 2'd1;
  localparam logic [1:0] CMD_LANDING  = 2'd2;
  localparam logic [1:0] CMD_OTHER    = 2'd3;

  localparam logic [1:0] REG_EXIT_DISTANCE  = 2'd0;
  localparam logic [1:0] REG_ENTER_DISTANCE = 2'd1;
  localparam logic [1:0] REG_EXIT_DWELL     = 2'd2;
  localparam logic [1:0] REG_ENTER_DWELL    = 2'd3;

  localparam logic [15:0] EXIT_DISTANCE_RST  = 16'd1000;
  localparam logic [15:0] ENTER_DISTANCE_RST = 16'd500;
  localparam logic [15:0] EXIT_DWELL_RST     = 16'd3000;
  localparam logic [15:0] ENTER_DWELL_RST    = 16'd3000;

  typedef struct packed {
    logic        func;
    logic [31:0] now_ms;
    logic [1:0]  command;
    logic [15:0] distance_mm;
    logic        motion_seen;
    logic        button_pressed;
    logic        pre_alarm;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       led_inside;
    logic       led_alarm;
    logic       door_open;
    logic [2:0] message;
    logic       is_alarm;
  } out_item_t;

  typedef struct packed {
    logic [15:0] exit_distance_mm;
    logic [15:0] enter_distance_mm;
    logic [15:0] exit_dwell_ms;
    logic [15:0] enter_dwell_ms;
  } cfg_t;

endpackage

@@ hdl/hds_regs.sv @@
// Configuration register file: thresholds and dwell times.
module hds_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [15:0]       wr_data,
  output hds_pkg::cfg_t     cfg
);

  hds_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.exit_distance_mm  <= hds_pkg::EXIT_DISTANCE_RST;
      regs.enter_distance_mm <= hds_pkg::ENTER_DISTANCE_RST;
      regs.exit_dwell_ms     <= hds_pkg::EXIT_DWELL_RST;
      regs.enter_dwell_ms    <= hds_pkg::ENTER_DWELL_RST;
    end else if (wr_en) begin
      case (wr_index)
        hds_pkg::REG_EXIT_DISTANCE:  regs.exit_distance_mm  <= wr_data;
        hds_pkg::REG_ENTER_DISTANCE: regs.enter_distance_mm <= wr_data;
        hds_pkg::REG_EXIT_DWELL:     regs.exit_dwell_ms     <= wr_data;
        hds_pkg::REG_ENTER_DWELL:    regs.enter_dwell_ms    <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

@@ hdl/hds_core.sv @@
// Mode state machine, dwell timing and result formation for one item.
module hds_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  hds_pkg::in_item_t     item,
  input  hds_pkg::cfg_t         cfg,
  output hds_pkg::out_item_t    result
);

  hds_pkg::mode_t cur_mode, cur_mode_next;
  logic [31:0]    mode_start_ms, mode_start_ms_next;
  logic           inside_lamp, inside_lamp_next;
  logic           alarm_lamp, alarm_lamp_next;
  logic           door_state, door_state_next;
  hds_pkg::msg_t  msg;

  logic [31:0] elapsed;
  logic        beyond_exit, exit_done, below_enter, enter_done;
  logic        start_takeoff, start_landing;

  assign elapsed       = item.now_ms - mode_start_ms;
  assign beyond_exit   = item.distance_mm > cfg.exit_distance_mm;
  assign below_enter   = item.distance_mm < cfg.enter_distance_mm;
  assign exit_done     = beyond_exit && (elapsed > {16'd0, cfg.exit_dwell_ms});
  assign enter_done    = below_enter && (elapsed > {16'd0, cfg.enter_dwell_ms});
  assign start_takeoff = (item.command == hds_pkg::CMD_TAKE_OFF) && !item.pre_alarm;
  assign start_landing = (item.command == hds_pkg::CMD_LANDING) && !item.pre_alarm
                         && item.motion_seen;

  // next mode
  always_comb begin
    cur_mode_next = cur_mode;
    if (item.func == hds_pkg::FUNC_ALARM) begin
      cur_mode_next = hds_pkg::MODE_ALARM;
    end else begin
      case (cur_mode)
        hds_pkg::MODE_REST:     if (start_takeoff) cur_mode_next = hds_pkg::MODE_TAKE_OFF;
        hds_pkg::MODE_TAKE_OFF: if (exit_done) cur_mode_next = hds_pkg::MODE_OUT;
        hds_pkg::MODE_OUT:      if (start_landing) cur_mode_next = hds_pkg::MODE_LANDING;
        hds_pkg::MODE_LANDING:  if (enter_done) cur_mode_next = hds_pkg::MODE_REST;
        hds_pkg::MODE_ALARM:    if (item.button_pressed) cur_mode_next = hds_pkg::MODE_REST;
        default:                cur_mode_next = cur_mode;
      endcase
    end
  end

  // lamps, door, start time and message
  always_comb begin
    mode_start_ms_next = mode_start_ms;
    inside_lamp_next   = inside_lamp;
    alarm_lamp_next    = alarm_lamp;
    door_state_next    = door_state;
    msg                = hds_pkg::MSG_NONE;
    if (item.func == hds_pkg::FUNC_ALARM) begin
      if (cur_mode != hds_pkg::MODE_ALARM) begin
        inside_lamp_next = 1'b0;
        alarm_lamp_next  = 1'b1;
        door_state_next  = 1'b0;
        msg              = hds_pkg::MSG_ALARM;
      end
    end else begin
      case (cur_mode)
        hds_pkg::MODE_REST: begin
          if (start_takeoff) begin
            inside_lamp_next   = 1'b0;
            door_state_next    = 1'b1;
            mode_start_ms_next = item.now_ms;
            msg                = hds_pkg::MSG_TAKE_OFF;
          end
        end
        hds_pkg::MODE_TAKE_OFF: begin
          if (!beyond_exit) begin
            mode_start_ms_next = item.now_ms;
          end else if (exit_done) begin
            door_state_next = 1'b0;
            msg             = hds_pkg::MSG_OUT;
          end
        end
        hds_pkg::MODE_OUT: begin
          if (start_landing) begin
            door_state_next    = 1'b1;
            mode_start_ms_next = item.now_ms;
            msg                = hds_pkg::MSG_LANDING;
          end
        end
        hds_pkg::MODE_LANDING: begin
          if (!below_enter) begin
            mode_start_ms_next = item.now_ms;
          end else if (enter_done) begin
            door_state_next  = 1'b0;
            inside_lamp_next = 1'b1;
            msg              = hds_pkg::MSG_INSIDE;
          end
        end
        hds_pkg::MODE_ALARM: begin
          if (item.button_pressed) begin
            alarm_lamp_next  = 1'b0;
            inside_lamp_next = 1'b1;
            msg              = hds_pkg::MSG_REST;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode      <= hds_pkg::MODE_REST;
      mode_start_ms <= 32'd0;
      inside_lamp   <= 1'b1;
      alarm_lamp    <= 1'b0;
      door_state    <= 1'b0;
    end else if (step) begin
      cur_mode      <= cur_mode_next;
      mode_start_ms <= mode_start_ms_next;
      inside_lamp   <= inside_lamp_next;
      alarm_lamp    <= alarm_lamp_next;
      door_state    <= door_state_next;
    end
  end

  assign result.mode       = cur_mode_next;
  assign result.led_inside = inside_lamp_next;
  assign result.led_alarm  = alarm_lamp_next;
  assign result.door_open  = door_state_next;
  assign result.message    = msg;
  assign result.is_alarm   = (cur_mode_next == hds_pkg::MODE_ALARM);

endmodule

@@ hdl/hangar_door_sequencer.sv @@
// Hangar door sequencer top level: input register, sequencer core, result register.
// Takes one item per clock while the result side does not stall, and returns one result
// for each, held first in the input register and then in the result register. The mode
// state updates as an item leaves the input register, so the following item sees it
// at once. in_stall rises only while both the input and the result register hold
// data and the result is stalled. Configuration writes are always ready and take
// effect on the next cycle; write only while no item is in flight.
module hangar_door_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hds_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hds_pkg::out_item_t   out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  hds_pkg::cfg_t      cfg;
  hds_pkg::in_item_t  item;
  hds_pkg::out_item_t result;
  logic               item_valid;
  logic               advance, step, accept;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign step      = item_valid && advance;
  assign in_stall  = item_valid && !advance;
  assign accept    = in_valid && !in_stall;

  hds_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  hds_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_alarm_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.is_alarm == (out_data.mode == hds_pkg::MODE_ALARM)))
    else $error("is_alarm does not match mode");

  a_alarm_lamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.led_alarm == out_data.is_alarm))
    else $error("alarm lamp outside alarm mode");

  a_door_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.door_open) |->
      (out_data.mode == hds_pkg::MODE_TAKE_OFF || out_data.mode == hds_pkg::MODE_LANDING))
    else $error("door open outside take-off or landing");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");
`endif

endmodule

@@ test/hds_door_checker.sv @@
// Checker for the hangar door sequencer: tracks the channels, predicts each result, compares.
`timescale 1ns / 1ps
module hds_door_checker
  import hds_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int        fails,
  output int        pending,
  output mode_t     pred_mode
);

  cfg_t        regs_q;
  mode_t       door_mode;
  logic [31:0] start_ms;
  logic        lamp_inside;
  logic        lamp_alarm;
  logic        door_drive;
  out_item_t   expected_q[$];

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("%0t ns: mismatch on %s, got %0d, want %0d", $time, what, got, want);
    fails++;
  endtask

  function automatic out_item_t door_step(input in_item_t it);
    msg_t      msg;
    out_item_t r;
    msg = MSG_NONE;
    if (it.func == FUNC_ALARM) begin
      if (door_mode != MODE_ALARM) begin
        door_mode   = MODE_ALARM;
        lamp_inside = 1'b0;
        lamp_alarm  = 1'b1;
        door_drive  = 1'b0;
        msg         = MSG_ALARM;
      end
    end else begin
      case (door_mode)
        MODE_REST: begin
          if (it.command == CMD_TAKE_OFF && !it.pre_alarm) begin
            door_mode   = MODE_TAKE_OFF;
            lamp_inside = 1'b0;
            door_drive  = 1'b1;
            start_ms    = it.now_ms;
            msg         = MSG_TAKE_OFF;
          end
        end
        MODE_TAKE_OFF: begin
          if (it.distance_mm > regs_q.exit_distance_mm) begin
            if (32'(it.now_ms - start_ms) > {16'd0, regs_q.exit_dwell_ms}) begin
              door_mode  = MODE_OUT;
              door_drive = 1'b0;
              msg        = MSG_OUT;
            end
          end else begin
            start_ms = it.now_ms;
          end
        end
        MODE_OUT: begin
          if (it.command == CMD_LANDING && !it.pre_alarm && it.motion_seen) begin
            door_mode  = MODE_LANDING;
            door_drive = 1'b1;
            start_ms   = it.now_ms;
            msg        = MSG_LANDING;
          end
        end
        MODE_LANDING: begin
          if (it.distance_mm < regs_q.enter_distance_mm) begin
            if (32'(it.now_ms - start_ms) > {16'd0, regs_q.enter_dwell_ms}) begin
              door_mode   = MODE_REST;
              door_drive  = 1'b0;
              lamp_inside = 1'b1;
              msg         = MSG_INSIDE;
            end
          end else begin
            start_ms = it.now_ms;
          end
        end
        MODE_ALARM: begin
          if (it.button_pressed) begin
            door_mode   = MODE_REST;
            lamp_alarm  = 1'b0;
            lamp_inside = 1'b1;
            msg         = MSG_REST;
          end
        end
        default: ;
      endcase
    end
    r.mode       = door_mode;
    r.led_inside = lamp_inside;
    r.led_alarm  = lamp_alarm;
    r.door_open  = door_drive;
    r.message    = msg;
    r.is_alarm   = (door_mode == MODE_ALARM);
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      regs_q      = '{EXIT_DISTANCE_RST, ENTER_DISTANCE_RST, EXIT_DWELL_RST, ENTER_DWELL_RST};
      door_mode   = MODE_REST;
      start_ms    = '0;
      lamp_inside = 1'b1;
      lamp_alarm  = 1'b0;
      door_drive  = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("result with none expected", out_data, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.mode !== want.mode) report("mode", out_data.mode, want.mode);
          if (out_data.led_inside !== want.led_inside)
            report("led_inside", out_data.led_inside, want.led_inside);
          if (out_data.led_alarm !== want.led_alarm)
            report("led_alarm", out_data.led_alarm, want.led_alarm);
          if (out_data.door_open !== want.door_open)
            report("door_open", out_data.door_open, want.door_open);
          if (out_data.message !== want.message)
            report("message", out_data.message, want.message);
          if (out_data.is_alarm !== want.is_alarm)
            report("is_alarm", out_data.is_alarm, want.is_alarm);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EXIT_DISTANCE:  regs_q.exit_distance_mm  = cfg_data;
          REG_ENTER_DISTANCE: regs_q.enter_distance_mm = cfg_data;
          REG_EXIT_DWELL:     regs_q.exit_dwell_ms     = cfg_data;
          REG_ENTER_DWELL:    regs_q.enter_dwell_ms    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_q.push_back(door_step(in_data));
    end
    pending   = expected_q.size();
    pred_mode = door_mode;
  end

endmodule

@@ test/hangar_door_sequencer_tb.sv @@
// Testbench top for the hangar door sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module hangar_door_sequencer_tb;
  import hds_pkg::*;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  in_item_t    in_data   = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = REG_EXIT_DISTANCE;
  logic [15:0] cfg_data  = '0;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_ready;

  int          fails;
  int          pending;
  mode_t       pred_mode;

  logic        in_fire  = 1'b0;
  logic        cfg_fire = 1'b0;
  int          snd_idle = 7;
  int          rcv_idle = 77;
  int          hold_req  = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic [31:0] clock_ms = '0;
  cfg_t        cur_cfg = '{EXIT_DISTANCE_RST, ENTER_DISTANCE_RST, EXIT_DWELL_RST, ENTER_DWELL_RST};

  always #6 clk = ~clk;

  hangar_door_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hds_door_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending),
    .pred_mode (pred_mode)
  );

  // transfer flags, sampled at the rising edge and read at the falling edge
  always @(posedge clk) begin
    in_fire  <= in_valid && !in_stall;
    cfg_fire <= cfg_valid && cfg_ready;
  end

  // result side: random stall plus a long hold-off at the start of each phase
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 90;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (rcv_idle != 0) && ($urandom_range(99) < rcv_idle);
    end
  end

  initial begin
    #3_000_000;
    $display("[hangar_door_sequencer] ERROR");
    $finish;
  end

  function automatic in_item_t mk(input logic func, input logic [31:0] now,
                                  input logic [1:0] cmd, input logic [15:0] distance,
                                  input logic motion, input logic button, input logic pre);
    in_item_t it;
    it.func           = func;
    it.now_ms         = now;
    it.command        = cmd;
    it.distance_mm    = distance;
    it.motion_seen    = motion;
    it.button_pressed = button;
    it.pre_alarm      = pre;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while (snd_idle != 0 && $urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(negedge clk); while (!in_fire);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input cfg_t c);
    logic [1:0]  regs [4];
    logic [15:0] vals [4];
    regs = '{REG_EXIT_DISTANCE, REG_ENTER_DISTANCE, REG_EXIT_DWELL, REG_ENTER_DWELL};
    vals = '{c.exit_distance_mm, c.enter_distance_mm, c.exit_dwell_ms, c.enter_dwell_ms};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(negedge clk); while (!cfg_fire);
    end
    cfg_valid <= 1'b0;
    cur_cfg = c;
  endtask

  // mostly well-formed steps for the predicted mode, some noise and alarms
  task automatic random_item(output in_item_t it);
    int unsigned pick;
    int unsigned step_max;
    pick = $urandom_range(99);
    step_max = ((cur_cfg.exit_dwell_ms > cur_cfg.enter_dwell_ms) ?
                cur_cfg.exit_dwell_ms : cur_cfg.enter_dwell_ms) / 8 + 2;
    if ($urandom_range(49) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(step_max);
    it.func           = FUNC_TICK;
    it.now_ms         = clock_ms;
    it.command        = 2'($urandom_range(3));
    it.distance_mm    = 16'($urandom_range(65535));
    it.motion_seen    = 1'($urandom_range(1));
    it.button_pressed = 1'($urandom_range(1));
    it.pre_alarm      = 1'($urandom_range(1));
    if (pick < 2) begin
      it.func = FUNC_ALARM;
    end else if (pick >= 8) begin
      case (pred_mode)
        MODE_REST: begin
          if ($urandom_range(9) < 6) it.command = CMD_TAKE_OFF;
          it.pre_alarm = ($urandom_range(9) == 0);
        end
        MODE_TAKE_OFF: begin
          if ($urandom_range(99) < 85 && cur_cfg.exit_distance_mm != 16'hFFFF)
            it.distance_mm = 16'($urandom_range(65535, cur_cfg.exit_distance_mm + 1));
          else
            it.distance_mm = 16'($urandom_range(cur_cfg.exit_distance_mm, 0));
        end
        MODE_OUT: begin
          if ($urandom_range(9) < 6) it.command = CMD_LANDING;
          it.motion_seen = ($urandom_range(99) < 85);
          it.pre_alarm   = ($urandom_range(9) == 0);
        end
        MODE_LANDING: begin
          if ($urandom_range(99) < 85 && cur_cfg.enter_distance_mm != 16'd0)
            it.distance_mm = 16'($urandom_range(cur_cfg.enter_distance_mm - 1, 0));
          else
            it.distance_mm = 16'($urandom_range(65535, cur_cfg.enter_distance_mm));
        end
        MODE_ALARM: it.button_pressed = ($urandom_range(9) < 3);
        default: ;
      endcase
    end
  endtask

  initial begin
    logic [31:0] t;
    logic [31:0] t2;
    in_item_t    it;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: full flight at reset settings, refusals, dwell edges, alarm
    send_item(mk(FUNC_TICK, 32'd0, CMD_OTHER, 16'd0, 1'b0, 1'b0, 1'b0));
    send_item(mk(FUNC_TICK, 32'd5, CMD_LANDING, 16'hFFFF, 1'b1, 1'b1, 1'b0));
    send_item(mk(FUNC_TICK, 32'd6, CMD_TAKE_OFF, 16'd0, 1'b0, 1'b0, 1'b1));
    send_item(mk(FUNC_TICK, 32'hFFFF_F000, CMD_TAKE_OFF, 16'd0, 1'b0, 1'b0, 1'b0));
    t = 32'hFFFF_FF00;
    send_item(mk(FUNC_TICK, t, CMD_LANDING, EXIT_DISTANCE_RST, 1'b1, 1'b0, 1'b0));
    send_item(mk(FUNC_TICK, t + 32'd3000, CMD_NONE, 16'hFFFF, 1'b0, 1'b0, 1'b0));
    send_item(mk(FUNC_TICK, t + 32'd3001, CMD_NONE, 16'hFFFF, 1'b0, 1'b0, 1'b0));
    t2 = t + 32'd5000;
    send_item(mk(FUNC_TICK, t2, CMD_TAKE_OFF, 16'd0, 1'b1, 1'b0, 1'b0));
    send_item(mk(FUNC_TICK, t2, CMD_LANDING, 16'd0, 1'b0, 1'b0, 1'b0));
    send_item(mk(FUNC_TICK, t2, CMD_LANDING, 16'd0, 1'b1, 1'b0, 1'b1));
    send_item(mk(FUNC_TICK, t2, CMD_LANDING, 16'hFFFF, 1'b1, 1'b0, 1'b0));
    send_item(mk(FUNC_TICK, t2 + 32'd10, CMD_NONE, ENTER_DISTANCE_RST, 1'b0, 1'b0, 1'b0));
    send_item(mk(FUNC_TICK, t2 + 32'd3010, CMD_NONE, 16'd0, 1'b0, 1'b0, 1'b0));
    send_item(mk(FUNC_TICK, t2 + 32'd3011, CMD_NONE, 16'd0, 1'b0, 1'b0, 1'b0));
    send_item(mk(FUNC_TICK, 32'hFFFF_FFFF, CMD_TAKE_OFF, 16'hFFFF, 1'b1, 1'b1, 1'b0));
    send_item(mk(FUNC_ALARM, 32'hFFFF_FFFF, CMD_OTHER, 16'hFFFF, 1'b1, 1'b1, 1'b1));
    send_item(mk(FUNC_ALARM, 32'd0, CMD_NONE, 16'd0, 1'b0, 1'b0, 1'b0));
    send_item(mk(FUNC_TICK, 32'd7, CMD_TAKE_OFF, 16'd0, 1'b1, 1'b0, 1'b0));
    send_item(mk(FUNC_TICK, 32'd8, CMD_NONE, 16'd0, 1'b0, 1'b1, 1'b1));
    send_item(mk(FUNC_TICK, 32'd9, CMD_NONE, 16'hFFFF, 1'b1, 1'b0, 1'b0));

    clock_ms = $urandom;
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      if (ph == 2) begin
        snd_idle = 77;
        rcv_idle = 7;
      end
      if (ph == 4) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      case (ph)
        1: begin
          set_config('{16'd0, 16'hFFFF, 16'd0, 16'd0});
          clock_ms = 32'hFFFF_FFF0;
        end
        2: begin
          set_config('{16'hFFFE, 16'd1, 16'hFFFF, 16'hFFFF});
          clock_ms = 32'hFFFF_0000;
        end
        3: set_config('{16'($urandom_range(60000, 100)), 16'($urandom_range(60000, 100)),
                        16'($urandom_range(400)), 16'($urandom_range(400))});
        4: set_config('{16'hFFFF, 16'd0, 16'($urandom_range(400)), 16'($urandom_range(400))});
        default: ;
      endcase
      hold_req++;
      for (int n = 0; n < 170; n++) begin
        random_item(it);
        send_item(it);
      end
    end

    wait_idle();
    repeat (6) @(negedge clk);
    if (fails == 0) begin
      $display("[hangar_door_sequencer] OK");
    end else begin
      $display("[hangar_door_sequencer] ERROR");
    end
    $finish;
  end

endmodule
